### rtl/ppt_pkg.sv
`default_nettype none
package ppt_pkg;

  // Fixed-point formats.
  localparam int COORD_FRAC_BITS = 16;
  localparam int Q30_SHIFT = 30;
  localparam int Q30_ONE = 1 << 30;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROT_W_X = 3'd0;
  localparam logic [2:0] REG_ROT_Y_Z = 3'd1;
  localparam logic [2:0] REG_AXIS_X = 3'd2;
  localparam logic [2:0] REG_AXIS_Y = 3'd3;
  localparam logic [2:0] REG_AXIS_Z = 3'd4;

  localparam logic [63:0] ROT_W_X_RESET = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ROT_Y_Z_RESET = 64'h0000_0000_0000_0000;
  localparam logic [63:0] AXIS_RESET = 64'h0001_0000_0000_0000;

  // Pipeline stage map.
  localparam int ST_IN = 0;
  localparam int ST_MUL = 1;
  localparam int ST_RND = 2;
  localparam int ST_MAG = 3;
  localparam int ST_ACC = 4;
  localparam int ST_SHF = 5;
  localparam int ST_SQR = 6;
  localparam int ST_SUM = 7;
  localparam int SQRT_STEPS = 32;
  localparam int ST_SQRT0 = ST_SUM + 1;
  localparam int ST_SQRT_END = ST_SUM + SQRT_STEPS;
  localparam int ST_NDIV = ST_SQRT_END + 1;
  localparam int DIV_STEPS = 31;
  localparam int ST_DIV_END = ST_NDIV + DIV_STEPS;
  localparam int ST_OUT = ST_DIV_END + 1;
  localparam int NUM_ST = ST_OUT + 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] scl_x;
    logic signed [31:0] scl_y;
    logic signed [31:0] scl_z;
  } pt_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_quat_x;
    logic signed [31:0] new_quat_y;
    logic signed [31:0] new_quat_z;
    logic signed [31:0] new_quat_w;
    logic signed [31:0] new_scl_x;
    logic signed [31:0] new_scl_y;
    logic signed [31:0] new_scl_z;
    logic sat_flag;
  } res_t;

  // Position and scale results traveling alongside the quaternion normalizer.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] scl;
    logic sat;
  } pos_res_t;

  // Normalized magnitudes, signs and zero mark carried through the normalizer.
  typedef struct packed {
    logic [3:0][29:0] nm;
    logic [3:0] sg;
    logic zero;
  } qcry_t;

  // Returns {saturated, value}.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Round to nearest, ties toward plus infinity.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ppt_qnorm.sv
`default_nettype none
module ppt_qnorm (
  input wire logic clk,
  input wire logic [ppt_pkg::ST_OUT:ppt_pkg::ST_MAG] en,
  input wire logic signed [63:0] h [4],
  output logic signed [31:0] q [4]
);

  logic [62:0] mag3 [4];
  logic [3:0] sg3;
  logic [62:0] mag4 [4];
  logic [3:0] sg4;
  logic [5:0] len4;
  logic zero4;
  logic [62:0] mx;
  logic [5:0] len;
  logic [29:0] nm [4];
  ppt_pkg::qcry_t cry [ppt_pkg::ST_SHF:ppt_pkg::ST_DIV_END];
  logic [59:0] sq6 [4];
  logic [63:0] rem [ppt_pkg::ST_SUM:ppt_pkg::ST_SQRT_END];
  logic [63:0] rt [ppt_pkg::ST_SUM:ppt_pkg::ST_SQRT_END];
  logic [30:0] dn [ppt_pkg::ST_NDIV:ppt_pkg::ST_DIV_END];
  logic [30:0] dr [ppt_pkg::ST_NDIV:ppt_pkg::ST_DIV_END][4];
  logic [30:0] dl [ppt_pkg::ST_NDIV:ppt_pkg::ST_DIV_END][4];
  logic [30:0] dq [ppt_pkg::ST_NDIV:ppt_pkg::ST_DIV_END][4];
  logic [30:0] nroot;
  logic [60:0] numer [4];

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_MAG]) begin
      for (int i = 0; i < 4; i++) begin
        mag3[i] <= h[i][63] ? 63'(-h[i]) : 63'(h[i]);
        sg3[i] <= h[i][63];
      end
    end
  end

  always_comb begin
    mx = mag3[0];
    for (int i = 1; i < 4; i++) begin
      if (mag3[i] > mx) mx = mag3[i];
    end
    len = '0;
    for (int b = 0; b < 63; b++) begin
      if (mx[b]) len = 6'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_ACC]) begin
      mag4 <= mag3;
      sg4 <= sg3;
      len4 <= len;
      zero4 <= (mx == '0);
    end
  end

  // Bring the largest magnitude into [2^29, 2^30).
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (len4 > 6'd30) begin
        nm[i] = 30'(mag4[i] >> (len4 - 6'd30));
      end else begin
        nm[i] = 30'(mag4[i] << (6'd30 - len4));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_SHF]) begin
      for (int i = 0; i < 4; i++) begin
        cry[ppt_pkg::ST_SHF].nm[i] <= nm[i];
      end
      cry[ppt_pkg::ST_SHF].sg <= sg4;
      cry[ppt_pkg::ST_SHF].zero <= zero4;
    end
    for (int k = ppt_pkg::ST_SQR; k <= ppt_pkg::ST_DIV_END; k++) begin
      if (en[k]) cry[k] <= cry[k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_SQR]) begin
      for (int i = 0; i < 4; i++) begin
        sq6[i] <= cry[ppt_pkg::ST_SHF].nm[i] * cry[ppt_pkg::ST_SHF].nm[i];
      end
    end
    if (en[ppt_pkg::ST_SUM]) begin
      rem[ppt_pkg::ST_SUM] <= 64'(sq6[0]) + 64'(sq6[1]) + 64'(sq6[2]) + 64'(sq6[3]);
      rt[ppt_pkg::ST_SUM] <= '0;
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar k = ppt_pkg::ST_SQRT0; k <= ppt_pkg::ST_SQRT_END; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * (k - ppt_pkg::ST_SQRT0));
    logic [63:0] trial;
    assign trial = rt[k - 1] + BITV;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (rem[k - 1] >= trial) begin
          rem[k] <= rem[k - 1] - trial;
          rt[k] <= (rt[k - 1] >> 1) + BITV;
        end else begin
          rem[k] <= rem[k - 1];
          rt[k] <= rt[k - 1] >> 1;
        end
      end
    end
  end

  // The quotient fits in 31 bits, so the top of the numerator is already
  // below the divisor and serves as the starting remainder.
  always_comb begin
    nroot = rt[ppt_pkg::ST_SQRT_END][30:0];
    for (int i = 0; i < 4; i++) begin
      numer[i] = {1'b0, cry[ppt_pkg::ST_SQRT_END].nm[i], 30'd0} + 61'(nroot[30:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_NDIV]) begin
      dn[ppt_pkg::ST_NDIV] <= nroot;
      for (int i = 0; i < 4; i++) begin
        dr[ppt_pkg::ST_NDIV][i] <= {1'b0, numer[i][60:31]};
        dl[ppt_pkg::ST_NDIV][i] <= numer[i][30:0];
        dq[ppt_pkg::ST_NDIV][i] <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage in each of four lanes.
  for (genvar k = ppt_pkg::ST_NDIV + 1; k <= ppt_pkg::ST_DIV_END; k++) begin : g_div
    logic [31:0] t [4];
    logic [3:0] ge;
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        t[i] = {dr[k - 1][i], dl[k - 1][i][30]};
        ge[i] = (t[i] >= {1'b0, dn[k - 1]});
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dn[k] <= dn[k - 1];
        for (int i = 0; i < 4; i++) begin
          dr[k][i] <= ge[i] ? 31'(t[i] - {1'b0, dn[k - 1]}) : t[i][30:0];
          dl[k][i] <= {dl[k - 1][i][29:0], 1'b0};
          dq[k][i] <= {dq[k - 1][i][29:0], ge[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_OUT]) begin
      for (int i = 0; i < 4; i++) begin
        if (cry[ppt_pkg::ST_DIV_END].zero) begin
          q[i] <= (i == 3) ? 32'(ppt_pkg::Q30_ONE) : 32'sd0;
        end else if (cry[ppt_pkg::ST_DIV_END].sg[i]) begin
          q[i] <= -$signed({1'b0, dq[ppt_pkg::ST_DIV_END][i]});
        end else begin
          q[i] <= $signed({1'b0, dq[ppt_pkg::ST_DIV_END][i]});
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/point_pose_transform.sv
// Point pose transform: scales, rotates and translates one point per cycle
// and composes its orientation with the configured rotation.
//
// Input transactions arrive on pt (pt_valid / pt_stall); results leave on
// res (res_valid / res_stall). A transaction is taken at a clock edge with
// valid high and stall low. Every input gives exactly one result, in order.
//
// The pipeline includes the 32-stage square root and the 31-stage
// divider of the quaternion normalizer. Throughput is one point per
// cycle while res_stall is low. Each stage advances when it is empty or
// the stage after it advances, so bubbles are squeezed out and input
// keeps flowing while a result waits, until the pipeline is full.
//
// The user writes the configuration registers through cfg_we / cfg_index /
// cfg_data only while the block is idle, unchecked by the block; writes to
// unknown indexes are dropped. Synchronous reset empties the pipeline and
// loads the identity rotation, unit scales and zero translations.
`default_nettype none
module point_pose_transform (
  input wire logic clk,
  input wire logic rst,
  input wire logic pt_valid,
  output logic pt_stall,
  input wire ppt_pkg::pt_t pt,
  output logic res_valid,
  input wire logic res_stall,
  output ppt_pkg::res_t res,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [63:0] cfg_data
);

  logic [63:0] rot_w_x, rot_y_z, axis_x_setup, axis_y_setup, axis_z_setup;
  logic signed [31:0] rw, rx, ry, rz;
  logic signed [31:0] scl_cfg [3];
  logic signed [31:0] trn_cfg [3];

  logic [ppt_pkg::NUM_ST-1:0] vld;
  logic [ppt_pkg::NUM_ST-1:0] en;

  ppt_pkg::pt_t s0;
  logic signed [31:0] pos_in [3];
  logic signed [31:0] scl_in [3];
  logic signed [63:0] pp [3];
  logic signed [63:0] ps [3];
  logic signed [63:0] hp [4][4];
  logic [32:0] sat_p [3];
  logic [32:0] sat_s [3];
  logic signed [31:0] sp [3];
  logic signed [31:0] nsc2 [3];
  logic f2;
  logic signed [63:0] h [4];
  logic signed [63:0] mp [3][3];
  logic signed [31:0] nsc3 [3];
  logic f3;
  logic [32:0] sat_o [3];
  logic signed [63:0] acc [3];
  ppt_pkg::pos_res_t pdly [ppt_pkg::ST_ACC:ppt_pkg::ST_OUT];
  logic signed [31:0] qo [4];

  logic signed [63:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [34:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [39:0] e [3][3];
  logic signed [31:0] mat [3][3];

  function automatic logic signed [31:0] clamp_one(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'(ppt_pkg::Q30_ONE)) begin
      r = 32'(ppt_pkg::Q30_ONE);
    end else if (v < -40'(ppt_pkg::Q30_ONE)) begin
      r = -32'(ppt_pkg::Q30_ONE);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_w_x <= ppt_pkg::ROT_W_X_RESET;
      rot_y_z <= ppt_pkg::ROT_Y_Z_RESET;
      axis_x_setup <= ppt_pkg::AXIS_RESET;
      axis_y_setup <= ppt_pkg::AXIS_RESET;
      axis_z_setup <= ppt_pkg::AXIS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppt_pkg::REG_ROT_W_X: rot_w_x <= cfg_data;
        ppt_pkg::REG_ROT_Y_Z: rot_y_z <= cfg_data;
        ppt_pkg::REG_AXIS_X: axis_x_setup <= cfg_data;
        ppt_pkg::REG_AXIS_Y: axis_y_setup <= cfg_data;
        ppt_pkg::REG_AXIS_Z: axis_z_setup <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rw = rot_w_x[63:32];
  assign rx = rot_w_x[31:0];
  assign ry = rot_y_z[63:32];
  assign rz = rot_y_z[31:0];
  assign scl_cfg[0] = axis_x_setup[63:32];
  assign scl_cfg[1] = axis_y_setup[63:32];
  assign scl_cfg[2] = axis_z_setup[63:32];
  assign trn_cfg[0] = axis_x_setup[31:0];
  assign trn_cfg[1] = axis_y_setup[31:0];
  assign trn_cfg[2] = axis_z_setup[31:0];

  // Rotation matrix, rebuilt from the registers through the registered
  // products p_* and then the registered matrix mat.
  always_ff @(posedge clk) begin
    p_xx <= rx * rx;
    p_yy <= ry * ry;
    p_zz <= rz * rz;
    p_xy <= rx * ry;
    p_xz <= rx * rz;
    p_yz <= ry * rz;
    p_wx <= rw * rx;
    p_wy <= rw * ry;
    p_wz <= rw * rz;
  end

  always_comb begin
    xx = 35'(ppt_pkg::rnd_shr(p_xx, ppt_pkg::Q30_SHIFT));
    yy = 35'(ppt_pkg::rnd_shr(p_yy, ppt_pkg::Q30_SHIFT));
    zz = 35'(ppt_pkg::rnd_shr(p_zz, ppt_pkg::Q30_SHIFT));
    xy = 35'(ppt_pkg::rnd_shr(p_xy, ppt_pkg::Q30_SHIFT));
    xz = 35'(ppt_pkg::rnd_shr(p_xz, ppt_pkg::Q30_SHIFT));
    yz = 35'(ppt_pkg::rnd_shr(p_yz, ppt_pkg::Q30_SHIFT));
    wx = 35'(ppt_pkg::rnd_shr(p_wx, ppt_pkg::Q30_SHIFT));
    wy = 35'(ppt_pkg::rnd_shr(p_wy, ppt_pkg::Q30_SHIFT));
    wz = 35'(ppt_pkg::rnd_shr(p_wz, ppt_pkg::Q30_SHIFT));
    e[0][0] = 40'(ppt_pkg::Q30_ONE) - ((40'(yy) + 40'(zz)) <<< 1);
    e[0][1] = (40'(xy) - 40'(wz)) <<< 1;
    e[0][2] = (40'(xz) + 40'(wy)) <<< 1;
    e[1][0] = (40'(xy) + 40'(wz)) <<< 1;
    e[1][1] = 40'(ppt_pkg::Q30_ONE) - ((40'(xx) + 40'(zz)) <<< 1);
    e[1][2] = (40'(yz) - 40'(wx)) <<< 1;
    e[2][0] = (40'(xz) - 40'(wy)) <<< 1;
    e[2][1] = (40'(yz) + 40'(wx)) <<< 1;
    e[2][2] = 40'(ppt_pkg::Q30_ONE) - ((40'(xx) + 40'(yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat[i][j] <= clamp_one(e[i][j]);
      end
    end
  end

  // Stage enables: load if res_stall is low or this or a later stage is empty.
  always_comb begin
    for (int k = 0; k < ppt_pkg::NUM_ST; k++) begin
      en[k] = !res_stall || ((~vld >> k) != '0);
    end
  end

  assign pt_stall = !en[ppt_pkg::ST_IN];
  assign res_valid = vld[ppt_pkg::ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[ppt_pkg::ST_IN]) vld[ppt_pkg::ST_IN] <= pt_valid;
      for (int k = 1; k < ppt_pkg::NUM_ST; k++) begin
        if (en[k]) vld[k] <= vld[k - 1];
      end
    end
  end

  assign pos_in[0] = s0.pos_x;
  assign pos_in[1] = s0.pos_y;
  assign pos_in[2] = s0.pos_z;
  assign scl_in[0] = s0.scl_x;
  assign scl_in[1] = s0.scl_y;
  assign scl_in[2] = s0.scl_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_p[i] = ppt_pkg::sat32(ppt_pkg::rnd_shr(pp[i], ppt_pkg::COORD_FRAC_BITS));
      sat_s[i] = ppt_pkg::sat32(ppt_pkg::rnd_shr(ps[i], ppt_pkg::COORD_FRAC_BITS));
      acc[i] = mp[i][0] + mp[i][1] + mp[i][2];
      sat_o[i] = ppt_pkg::sat32(ppt_pkg::rnd_shr(acc[i], ppt_pkg::Q30_SHIFT)
                                + 64'(trn_cfg[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ppt_pkg::ST_IN]) s0 <= pt;

    if (en[ppt_pkg::ST_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= pos_in[i] * scl_cfg[i];
        ps[i] <= scl_in[i] * scl_cfg[i];
      end
      // Hamilton product terms, rows ordered x, y, z, w.
      hp[0][0] <= rw * s0.quat_x;
      hp[0][1] <= rx * s0.quat_w;
      hp[0][2] <= ry * s0.quat_z;
      hp[0][3] <= rz * s0.quat_y;
      hp[1][0] <= rw * s0.quat_y;
      hp[1][1] <= rx * s0.quat_z;
      hp[1][2] <= ry * s0.quat_w;
      hp[1][3] <= rz * s0.quat_x;
      hp[2][0] <= rw * s0.quat_z;
      hp[2][1] <= rx * s0.quat_y;
      hp[2][2] <= ry * s0.quat_x;
      hp[2][3] <= rz * s0.quat_w;
      hp[3][0] <= rw * s0.quat_w;
      hp[3][1] <= rx * s0.quat_x;
      hp[3][2] <= ry * s0.quat_y;
      hp[3][3] <= rz * s0.quat_z;
    end

    if (en[ppt_pkg::ST_RND]) begin
      for (int i = 0; i < 3; i++) begin
        sp[i] <= sat_p[i][31:0];
        nsc2[i] <= sat_s[i][31:0];
      end
      f2 <= sat_p[0][32] | sat_p[1][32] | sat_p[2][32]
          | sat_s[0][32] | sat_s[1][32] | sat_s[2][32];
      h[0] <= (hp[0][0] >>> 2) + (hp[0][1] >>> 2) + (hp[0][2] >>> 2) - (hp[0][3] >>> 2);
      h[1] <= (hp[1][0] >>> 2) - (hp[1][1] >>> 2) + (hp[1][2] >>> 2) + (hp[1][3] >>> 2);
      h[2] <= (hp[2][0] >>> 2) + (hp[2][1] >>> 2) - (hp[2][2] >>> 2) + (hp[2][3] >>> 2);
      h[3] <= (hp[3][0] >>> 2) - (hp[3][1] >>> 2) - (hp[3][2] >>> 2) - (hp[3][3] >>> 2);
    end

    if (en[ppt_pkg::ST_MAG]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp[i][j] <= mat[i][j] * sp[j];
        end
      end
      nsc3 <= nsc2;
      f3 <= f2;
    end

    if (en[ppt_pkg::ST_ACC]) begin
      for (int i = 0; i < 3; i++) begin
        pdly[ppt_pkg::ST_ACC].pos[i] <= sat_o[i][31:0];
        pdly[ppt_pkg::ST_ACC].scl[i] <= nsc3[i];
      end
      pdly[ppt_pkg::ST_ACC].sat <= f3 | sat_o[0][32] | sat_o[1][32] | sat_o[2][32];
    end

    for (int k = ppt_pkg::ST_ACC + 1; k <= ppt_pkg::ST_OUT; k++) begin
      if (en[k]) pdly[k] <= pdly[k - 1];
    end
  end

  ppt_qnorm u_qnorm (
    .clk(clk),
    .en(en[ppt_pkg::ST_OUT:ppt_pkg::ST_MAG]),
    .h(h),
    .q(qo)
  );

  always_comb begin
    res.new_pos_x = pdly[ppt_pkg::ST_OUT].pos[0];
    res.new_pos_y = pdly[ppt_pkg::ST_OUT].pos[1];
    res.new_pos_z = pdly[ppt_pkg::ST_OUT].pos[2];
    res.new_quat_x = qo[0];
    res.new_quat_y = qo[1];
    res.new_quat_z = qo[2];
    res.new_quat_w = qo[3];
    res.new_scl_x = pdly[ppt_pkg::ST_OUT].scl[0];
    res.new_scl_y = pdly[ppt_pkg::ST_OUT].scl[1];
    res.new_scl_z = pdly[ppt_pkg::ST_OUT].scl[2];
    res.sat_flag = pdly[ppt_pkg::ST_OUT].sat;
  end

`ifndef ASSERT_OFF
  a_take_input: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_stall |=> vld[ppt_pkg::ST_IN])
    else $error("accepted transaction did not enter the first stage");

  a_flow_through: assert property (@(posedge clk)
    !res_stall |-> !pt_stall)
    else $error("input stalled while the output side was free");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
